@@ rtl/core/bbpp_pkg.sv @@
// Shared types, constants and helpers for the bang-bang profile planner.
`timescale 1ns / 1ps
package bbpp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 10;
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int TOL_W        = 16;
    localparam int DUR_W        = 41;
    localparam int QUO_W        = 64 + FRAC_BITS;
    localparam logic [DUR_W-1:0] DUR_CAP = {1'b1, {(DUR_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KIND_BRAKE_REV  = 3'd0,
        KIND_ACCEL      = 3'd1,
        KIND_CRUISE     = 3'd2,
        KIND_DECEL      = 3'd3,
        KIND_BRAKE_OVER = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_QDIV = 2'd2,
        OP_SQRT = 2'd3
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_VV, S_SQ, S_DEC, S_PICK, S_LIM, S_RA,
        S_SQRT, S_PK2, S_DIST, S_DUR, S_UPD, S_EMIT
    } t_state;

    typedef struct packed {
        logic        valid;
        t_alu_op     op;
        logic [63:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic signed [31:0] target_displacement;
        logic signed [31:0] start_velocity;
        logic [30:0]        velocity_limit;
        logic [30:0]        accel_limit;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         segment_kind;
        logic signed [31:0] segment_accel;
        logic [30:0]        segment_duration;
        logic signed [31:0] segment_distance;
        logic signed [31:0] segment_end_velocity;
        logic [30:0]        plan_time;
        logic               last_segment;
    } t_out_item;

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
            r = $signed(32'h8000_0000);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] sat_u31(input logic [DUR_W-1:0] v);
        logic [30:0] r;
        if (v > DUR_W'(31'h7FFF_FFFF)) begin
            r = 31'h7FFF_FFFF;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bbpp_if.sv @@
// Valid/ready channel interfaces for planner input items and segment results.
`timescale 1ns / 1ps
interface bbpp_in_if import bbpp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bbpp_out_if import bbpp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bbpp_alu.sv @@
// Shared bit-serial unit: multiply, divide, scaled divide and integer square root.
`timescale 1ns / 1ps
module bbpp_alu import bbpp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_alu_op          r_op, n_op;
    logic [6:0]       r_cnt, n_cnt;
    logic [QUO_W-1:0] r_x, n_x;
    logic [63:0]      r_acc, n_acc;
    logic [63:0]      r_y, n_y;
    logic [31:0]      r_p, n_p;

    logic [32:0] w_trial;
    logic        w_ge;
    logic [63:0] w_sq_s;
    logic        w_sq_ge;
    logic [63:0] w_qsat;

    assign w_trial = {r_p, r_x[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_y[31:0]};
    assign w_sq_s  = r_acc | r_y;
    assign w_sq_ge = r_x[63:0] >= w_sq_s;
    assign w_qsat  = (|r_x[QUO_W-1:DUR_W-1]) ? 64'(DUR_CAP) : r_x[63:0];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_acc  = r_acc;
        n_y    = r_y;
        n_p    = r_p;
        if (!r_busy && i_req.valid) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_acc  = '0;
            n_p    = '0;
            n_y    = {32'b0, i_req.b};
            case (i_req.op)
                OP_MUL: begin
                    n_x   = QUO_W'(i_req.a);
                    n_cnt = 7'd32;
                end
                OP_DIV: begin
                    // dividend sits on top so its bits leave first
                    n_x   = {i_req.a, {FRAC_BITS{1'b0}}};
                    n_cnt = 7'd64;
                end
                OP_QDIV: begin
                    // run through the fraction bits too for a scaled quotient
                    n_x   = {i_req.a, {FRAC_BITS{1'b0}}};
                    n_cnt = 7'(QUO_W);
                end
                default: begin
                    n_x   = QUO_W'(i_req.a);
                    n_y   = 64'h4000_0000_0000_0000;
                    n_cnt = 7'd32;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) n_acc = r_acc + r_x[63:0];
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                OP_DIV, OP_QDIV: begin
                    n_p = w_ge ? 32'(w_trial - {1'b0, r_y[31:0]}) : w_trial[31:0];
                    n_x = {r_x[QUO_W-2:0], w_ge};
                end
                default: begin
                    if (w_sq_ge) begin
                        n_x   = QUO_W'(r_x[63:0] - w_sq_s);
                        n_acc = (r_acc >> 1) | r_y;
                    end else begin
                        n_acc = r_acc >> 1;
                    end
                    n_y = r_y >> 2;
                end
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_acc <= n_acc;
        r_y   <= n_y;
        r_p   <= n_p;
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        case (r_op)
            OP_MUL:  o_rsp.result = r_acc;
            OP_DIV:  o_rsp.result = r_x[63:0];
            OP_QDIV: o_rsp.result = w_qsat;
            default: o_rsp.result = r_acc;
        endcase
    end

endmodule

@@ rtl/core/bang_bang_profile_planner_top.sv @@
// Top level of the one-axis bang-bang profile planner.
// Takes one move (displacement, start velocity, speed and acceleration limits, Q16.16)
// and returns its profile segments one transfer at a time, the final one flagged by
// last_segment; a move already within stop_tolerance returns nothing. A new move is
// taken only once the previous plan has been fully handed to the output register.
// All arithmetic runs on one shared bit-serial unit at one bit (square root: one result
// bit) per cycle. A full plan holds at most ten segments.
`timescale 1ns / 1ps
module bang_bang_profile_planner_top import bbpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TOL_W-1:0]  i_cfg_wdata,
    bbpp_in_if.sink           i_in,
    bbpp_out_if.source        o_out
);

    t_state r_state, n_state;

    logic [TOL_W-1:0]     r_tol;
    logic                 r_neg, n_neg;
    logic [31:0]          r_w, n_w;
    logic signed [32:0]   r_vel, n_vel;
    logic [30:0]          r_vlim, n_vlim;
    logic [30:0]          r_alim, n_alim;
    logic signed [63:0]   r_pos, n_pos;
    logic [DUR_W-1:0]     r_t, n_t;
    logic [SEG_CNT_W-1:0] r_n, n_n;
    logic [63:0]          r_vv, n_vv;
    logic [63:0]          r_vlim_sq, n_vlim_sq;
    logic [63:0]          r_dec, n_dec;
    logic [63:0]          r_tmp, n_tmp;
    logic [31:0]          r_pk, n_pk;
    t_kind                r_kind, n_kind;
    logic signed [63:0]   r_dist, n_dist;
    logic [DUR_W-1:0]     r_dur, n_dur;
    logic                 r_issued, n_issued;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic [31:0]        w_av;
    logic signed [63:0] w_rem;
    logic signed [63:0] w_diff;
    logic [63:0]        w_mag;
    logic               w_near;
    logic [31:0]        w_a2;
    logic [63:0]        w_h;
    logic               w_over;
    logic               w_slow;
    logic               w_rem_gt_dec;
    logic               w_in_lim;
    logic               w_alu_state;
    logic               w_out_free;
    logic               w_last;
    logic               w_in_xfer;
    logic signed [32:0] w_d33;
    logic signed [32:0] w_v33;
    logic [DUR_W:0]     w_tsum;
    logic signed [31:0] w_acc;
    logic signed [31:0] w_fv;

    bbpp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_av         = r_vel[32] ? 32'(-r_vel) : r_vel[31:0];
    assign w_rem        = $signed({32'b0, r_w}) - r_pos;
    assign w_diff       = r_pos - $signed({32'b0, r_w});
    assign w_mag        = w_diff[63] ? 64'(-w_diff) : 64'(w_diff);
    assign w_near       = w_mag <= 64'(r_tol);
    assign w_a2         = {r_alim, 1'b0};
    assign w_h          = r_vv >> 1;
    assign w_over       = !r_vel[32] && (r_vel[31:0] > {1'b0, r_vlim});
    assign w_slow       = w_av < {1'b0, r_vlim};
    assign w_rem_gt_dec = w_rem > $signed(r_dec);
    assign w_in_lim     = 64'(w_rem) <= w_rsp.result;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_last       = w_near || (r_n == SEG_CNT_W'(MAX_SEGMENTS));
    assign w_in_xfer    = i_in.valid && i_in.ready;
    assign w_d33        = {i_in.data.target_displacement[31], i_in.data.target_displacement};
    assign w_v33        = {i_in.data.start_velocity[31], i_in.data.start_velocity};
    assign w_tsum       = {1'b0, r_t} + {1'b0, r_dur};

    assign w_alu_state = (r_state == S_VV)   || (r_state == S_SQ)  || (r_state == S_DEC) ||
                         (r_state == S_LIM)  || (r_state == S_RA)  || (r_state == S_SQRT) ||
                         (r_state == S_PK2)  || (r_state == S_DIST) || (r_state == S_DUR);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // operand selection for the shared unit
    always_comb begin
        w_req.valid = w_alu_state && !r_issued && !w_rsp.busy;
        w_req.op    = OP_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_state)
            S_VV: begin
                w_req.a = {33'b0, r_vlim};
                w_req.b = {1'b0, r_vlim};
            end
            S_SQ: begin
                w_req.a = {32'b0, w_av};
                w_req.b = w_av;
            end
            S_DEC: begin
                w_req.op = OP_DIV;
                w_req.a  = r_vv;
                w_req.b  = w_a2;
            end
            S_LIM: begin
                w_req.op = OP_DIV;
                w_req.a  = r_vlim_sq - w_h;
                w_req.b  = {1'b0, r_alim};
            end
            S_RA: begin
                w_req.a = 64'(w_rem);
                w_req.b = {1'b0, r_alim};
            end
            S_SQRT: begin
                w_req.op = OP_SQRT;
                w_req.a  = r_tmp + w_h;
            end
            S_PK2: begin
                w_req.a = {32'b0, r_pk};
                w_req.b = r_pk;
            end
            S_DIST: begin
                w_req.op = OP_DIV;
                w_req.b  = w_a2;
                case (r_kind)
                    KIND_BRAKE_OVER: w_req.a = r_vv - r_vlim_sq;
                    KIND_ACCEL:      w_req.a = r_tmp - r_vv;
                    default:         w_req.a = r_vlim_sq;
                endcase
            end
            S_DUR: begin
                w_req.op = OP_QDIV;
                w_req.b  = {1'b0, r_alim};
                case (r_kind)
                    KIND_CRUISE: begin
                        w_req.a = 64'(r_dist);
                        w_req.b = {1'b0, r_vlim};
                    end
                    KIND_BRAKE_OVER: w_req.a = {32'b0, w_av - {1'b0, r_vlim}};
                    KIND_ACCEL:      w_req.a = {32'b0, r_pk - w_av};
                    default:         w_req.a = {32'b0, w_av};
                endcase
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_START;
            S_START: n_state = w_near ? S_IDLE : S_VV;
            S_VV:    if (w_rsp.done) n_state = S_SQ;
            S_SQ:    if (w_rsp.done) n_state = w_over ? S_DIST : S_DEC;
            S_DEC:   if (w_rsp.done) n_state = S_PICK;
            S_PICK: begin
                if (r_vel[32])                    n_state = S_DUR;
                else if (w_rem_gt_dec && w_slow)  n_state = S_LIM;
                else if (w_rem_gt_dec)            n_state = S_DIST;
                else                              n_state = S_DUR;
            end
            S_LIM:   if (w_rsp.done) n_state = w_in_lim ? S_RA : S_PK2;
            S_RA:    if (w_rsp.done) n_state = S_SQRT;
            S_SQRT:  if (w_rsp.done) n_state = S_PK2;
            S_PK2:   if (w_rsp.done) n_state = S_DIST;
            S_DIST:  if (w_rsp.done) n_state = S_DUR;
            S_DUR:   if (w_rsp.done) n_state = S_UPD;
            S_UPD:   n_state = S_EMIT;
            S_EMIT:  if (w_out_free) n_state = w_last ? S_IDLE : S_SQ;
            default: n_state = S_IDLE;
        endcase
    end

    // segment result fields, original direction
    always_comb begin
        case (r_kind)
            KIND_BRAKE_REV, KIND_ACCEL: w_acc = $signed({1'b0, r_alim});
            KIND_CRUISE:                w_acc = '0;
            default:                    w_acc = -$signed({1'b0, r_alim});
        endcase
        if (r_neg) w_acc = -w_acc;
        w_fv = r_neg ? -$signed(r_vel[31:0]) : $signed(r_vel[31:0]);
    end

    // datapath
    always_comb begin
        n_neg       = r_neg;
        n_w         = r_w;
        n_vel       = r_vel;
        n_vlim      = r_vlim;
        n_alim      = r_alim;
        n_pos       = r_pos;
        n_t         = r_t;
        n_n         = r_n;
        n_vv        = r_vv;
        n_vlim_sq   = r_vlim_sq;
        n_dec       = r_dec;
        n_tmp       = r_tmp;
        n_pk        = r_pk;
        n_kind      = r_kind;
        n_dist      = r_dist;
        n_dur       = r_dur;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        n_issued    = r_issued;
        if (w_req.valid)     n_issued = 1'b1;
        else if (w_rsp.done) n_issued = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_neg  = i_in.data.target_displacement[31];
                    n_w    = n_neg ? 32'(-w_d33) : 32'(w_d33);
                    n_vel  = n_neg ? -w_v33 : w_v33;
                    n_vlim = (i_in.data.velocity_limit == '0) ? 31'd1
                                                              : i_in.data.velocity_limit;
                    n_alim = (i_in.data.accel_limit == '0) ? 31'd1 : i_in.data.accel_limit;
                    n_pos  = '0;
                    n_t    = '0;
                    n_n    = '0;
                end
            end
            S_VV:  if (w_rsp.done) n_vlim_sq = w_rsp.result;
            S_SQ: begin
                if (w_rsp.done) begin
                    n_vv = w_rsp.result;
                    if (w_over) n_kind = KIND_BRAKE_OVER;
                end
            end
            S_DEC: if (w_rsp.done) n_dec = w_rsp.result;
            S_PICK: begin
                if (r_vel[32]) begin
                    n_kind = KIND_BRAKE_REV;
                    n_dist = -$signed(r_dec);
                end else if (w_rem_gt_dec && w_slow) begin
                    n_kind = KIND_ACCEL;
                end else if (w_rem_gt_dec) begin
                    n_kind = KIND_CRUISE;
                end else begin
                    n_kind = KIND_DECEL;
                    n_dist = $signed(r_dec);
                end
            end
            // peak capped at the speed limit when the distance is long enough
            S_LIM:  if (w_rsp.done && !w_in_lim) n_pk = {1'b0, r_vlim};
            S_RA:   if (w_rsp.done) n_tmp = w_rsp.result;
            S_SQRT: if (w_rsp.done) n_pk = w_rsp.result[31:0];
            S_PK2:  if (w_rsp.done) n_tmp = w_rsp.result;
            S_DIST: begin
                if (w_rsp.done) begin
                    n_dist = (r_kind == KIND_CRUISE) ? w_rem - $signed(w_rsp.result)
                                                     : $signed(w_rsp.result);
                end
            end
            S_DUR: if (w_rsp.done) n_dur = w_rsp.result[DUR_W-1:0];
            S_UPD: begin
                n_pos = r_pos + r_dist;
                case (r_kind)
                    KIND_ACCEL:                   n_vel = $signed({1'b0, r_pk});
                    KIND_CRUISE, KIND_BRAKE_OVER: n_vel = $signed({2'b0, r_vlim});
                    default:                      n_vel = '0;
                endcase
                n_t = (w_tsum > {1'b0, DUR_CAP}) ? DUR_CAP : w_tsum[DUR_W-1:0];
                n_n = r_n + SEG_CNT_W'(1);
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.segment_kind         = r_kind;
                    n_out.segment_accel        = w_acc;
                    n_out.segment_duration     = sat_u31(r_dur);
                    n_out.segment_distance     = sat_s32(r_dist);
                    n_out.segment_end_velocity = w_fv;
                    n_out.plan_time            = sat_u31(r_t);
                    n_out.last_segment         = w_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= TOL_W'(1);
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_tol <= i_cfg_wdata;
        end
        r_neg     <= n_neg;
        r_w       <= n_w;
        r_vel     <= n_vel;
        r_vlim    <= n_vlim;
        r_alim    <= n_alim;
        r_pos     <= n_pos;
        r_t       <= n_t;
        r_n       <= n_n;
        r_vv      <= n_vv;
        r_vlim_sq <= n_vlim_sq;
        r_dec     <= n_dec;
        r_tmp     <= n_tmp;
        r_pk      <= n_pk;
        r_kind    <= n_kind;
        r_dist    <= n_dist;
        r_dur     <= n_dur;
        r_out     <= n_out;
    end

endmodule

@@ rtl/core/bbpp_chk.sv @@
// Port-level checker for the planner top level, with its bind.
`timescale 1ns / 1ps
module bbpp_chk import bbpp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("result changed while stalled");

    // no new move while a plan is still being handed out
    a_plan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.last_segment |-> !i_in_ready)
        else $error("input taken in the middle of a plan");

    a_one_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second move taken right after a transfer");

endmodule

bind bang_bang_profile_planner_top bbpp_chk u_bbpp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.data)
);

@@ tb/sv/tb_bang_bang_profile_planner_top.sv @@
// Testbench for the bang-bang profile planner: directed and random moves checked against a segment predictor.
`timescale 1ns / 1ps
module tb_bang_bang_profile_planner_top;
    import bbpp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TOL_W-1:0] i_cfg_wdata;

    bbpp_in_if  in_ch ();
    bbpp_out_if out_ch ();

    bang_bang_profile_planner_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    localparam logic [63:0] TIME_CAP = 64'd1 << 40;

    t_out_item segments_due[$];
    logic [15:0] tol_model;
    int send_idle_pct;
    int recv_stall_pct;
    int error_count;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] scaled_quot(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (q >= (TIME_CAP >> FRAC_BITS)) return TIME_CAP;
        return (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
    endfunction

    function automatic logic signed [31:0] clamp_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [30:0] clamp_u31(input logic [63:0] v);
        return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    // Append the segments of one move to segments_due.
    task automatic plan_segments(input t_in_item it);
        logic signed [63:0] w, vel, pos, diff, acc, seg_dist, fv, rem, dec;
        logic [63:0] vlim, alim, mag, av, vv, dur, t, h, lim, pk, cr;
        t_kind kind;
        t_out_item seg;
        bit flip;
        int n;
        int first;
        w = it.target_displacement;
        vel = it.start_velocity;
        flip = w < 0;
        if (flip) begin
            w = -w;
            vel = -vel;
        end
        vlim = (it.velocity_limit == 0) ? 64'd1 : 64'(it.velocity_limit);
        alim = (it.accel_limit == 0) ? 64'd1 : 64'(it.accel_limit);
        pos = 0;
        t = 0;
        n = 0;
        first = segments_due.size();
        while (n < MAX_SEGMENTS) begin
            diff = pos - w;
            mag = (diff < 0) ? -diff : diff;
            if (mag <= 64'(tol_model)) break;
            av = (vel < 0) ? -vel : vel;
            vv = av * av;
            if (vel < 0) begin
                kind = KIND_BRAKE_REV;
                acc = alim;
                dur = scaled_quot(av, alim);
                seg_dist = -$signed(vv / (2 * alim));
                fv = 0;
            end else if (64'(vel) > vlim) begin
                kind = KIND_BRAKE_OVER;
                acc = -$signed(alim);
                dur = scaled_quot(av - vlim, alim);
                seg_dist = (vv - vlim * vlim) / (2 * alim);
                fv = vlim;
            end else begin
                rem = w - pos;
                dec = vv / (2 * alim);
                if (rem > dec && av < vlim) begin
                    h = vv / 2;
                    lim = (vlim * vlim - h) / alim;
                    kind = KIND_ACCEL;
                    acc = alim;
                    pk = (64'(rem) <= lim) ? root_floor(64'(rem) * alim + h) : vlim;
                    dur = scaled_quot(pk - av, alim);
                    seg_dist = (pk * pk - vv) / (2 * alim);
                    fv = pk;
                end else if (av >= vlim && rem > dec) begin
                    cr = rem - $signed(vlim * vlim / (2 * alim));
                    kind = KIND_CRUISE;
                    acc = 0;
                    dur = scaled_quot(cr, vlim);
                    seg_dist = cr;
                    fv = vlim;
                end else begin
                    kind = KIND_DECEL;
                    acc = -$signed(alim);
                    dur = scaled_quot(av, alim);
                    seg_dist = dec;
                    fv = 0;
                end
            end
            pos = pos + seg_dist;
            vel = fv;
            t = t + dur;
            if (t > TIME_CAP) t = TIME_CAP;
            seg.segment_kind = kind;
            seg.segment_accel = clamp_s32(flip ? -acc : acc);
            seg.segment_duration = clamp_u31(dur);
            seg.segment_distance = clamp_s32(seg_dist);
            seg.segment_end_velocity = clamp_s32(flip ? -fv : fv);
            seg.plan_time = clamp_u31(t);
            seg.last_segment = 1'b0;
            segments_due = {segments_due, seg};
            n++;
        end
        if (n > 0) segments_due[first + n - 1].last_segment = 1'b1;
    endtask

    task automatic send_move(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        plan_segments(it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 1'b0;
        // let the clock advance with valid low before the next move
        @(posedge i_clk);
    endtask

    task automatic drain_plans();
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] tol);
        drain_plans();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol_model = tol;
    endtask

    function automatic t_in_item make_move(input logic [31:0] d, input logic [31:0] v,
                                           input logic [30:0] vl, input logic [30:0] al);
        t_in_item it;
        it.target_displacement = d;
        it.start_velocity = v;
        it.velocity_limit = vl;
        it.accel_limit = al;
        return it;
    endfunction

    // Mostly realistic magnitudes, with occasional full-range bit patterns.
    function automatic t_in_item random_move();
        t_in_item it;
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            it = make_move($urandom, $urandom, 31'($urandom), 31'($urandom));
        end else begin
            it.target_displacement = $signed($urandom_range(32'h0100_0000)) >>> $urandom_range(12);
            if ($urandom_range(1)) it.target_displacement = -it.target_displacement;
            it.start_velocity = $signed($urandom_range(32'h0008_0000)) >>> $urandom_range(8);
            if ($urandom_range(1)) it.start_velocity = -it.start_velocity;
            if (sel == 1) it.start_velocity = 0;
            it.velocity_limit = 31'($urandom_range(32'h0004_0000, 1));
            it.accel_limit = 31'($urandom_range(32'h0008_0000, 1));
        end
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (segments_due.size() == 0) begin
                $display("%0t unexpected segment: actual %p", $time, out_ch.data);
                error_count++;
            end else begin
                if (out_ch.data !== segments_due[0]) begin
                    $display("%0t segment mismatch: expected %p actual %p",
                             $time, segments_due[0], out_ch.data);
                    error_count++;
                end
                void'(segments_due.pop_front());
            end
        end
    end

    task automatic test_directed();
        send_move(make_move(32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000));
        send_move(make_move(32'h0000_0001, 32'h0001_0000, 31'h0001_0000, 31'h0001_0000));
        send_move(make_move(32'h0010_0000, 32'h0000_0000, 31'h0002_0000, 31'h0001_0000));
        send_move(make_move(32'hFFF0_0000, 32'h0000_0000, 31'h0002_0000, 31'h0001_0000));
        send_move(make_move(32'h0010_0000, 32'hFFFE_0000, 31'h0002_0000, 31'h0001_0000));
        send_move(make_move(32'h0010_0000, 32'h0008_0000, 31'h0002_0000, 31'h0001_0000));
        send_move(make_move(32'h0000_4000, 32'h0000_0000, 31'h0100_0000, 31'h0001_0000));
        send_move(make_move(32'h0000_1000, 32'h0004_0000, 31'h0008_0000, 31'h0001_0000));
        send_move(make_move(32'h0010_0000, 32'h0000_0000, 31'h0000_0000, 31'h0000_0000));
        send_move(make_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_move(make_move(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h0000_0001));
        send_move(make_move(32'h7FFF_FFFF, 32'h0000_0000, 31'h0000_0001, 31'h0000_0001));
        send_move(make_move(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001, 31'h7FFF_FFFF));
        send_move(make_move(32'h0100_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0010));
        send_move(make_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0001, 31'h0000_0001));
    endtask

    task automatic test_tolerance_extremes();
        write_tolerance(16'hFFFF);
        send_move(make_move(32'h0000_FFFF, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000));
        send_move(make_move(32'hFFFF_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000));
        send_move(make_move(32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000));
        write_tolerance(16'h0000);
        send_move(make_move(32'h0000_0001, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000));
        send_move(make_move(32'h0003_0000, 32'h0001_8000, 31'h0001_0000, 31'h0000_8000));
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_move(random_move());
    endtask

    task automatic test_hold_until_drained();
        send_move(random_move());
        drain_plans();
        send_move(random_move());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        tol_model = 16'd1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance_extremes();
        write_tolerance(16'd1);
        test_random(90, 0, 0);
        test_random(60, 87, 0);
        test_hold_until_drained();
        write_tolerance(16'($urandom_range(2000)));
        test_random(60, 0, 87);
        test_random(70, 28, 28);
        write_tolerance(16'($urandom));
        test_random(70, 0, 0);
        drain_plans();
        if (error_count == 0) begin
            $display("[bang_bang_profile_planner_top] OK");
        end else begin
            $display("[bang_bang_profile_planner_top] ERROR");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("[bang_bang_profile_planner_top] ERROR");
        $finish;
    end
endmodule
